@@ design/swr_pkg.sv @@
`default_nettype none

package swr_pkg;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WORD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_WORD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH = 2'd3;

  localparam int WORD_W = 64;
  localparam int LEN_W  = 4;

  typedef struct packed {
    logic [WORD_W-1:0] search_word;
    logic [LEN_W-1:0]  search_len;
    logic [WORD_W-1:0] replace_word;
    logic [LEN_W-1:0]  replace_len;
  } cfg_t;

  // control half of a job: how many bytes to emit, and whether it ends the text
  typedef struct packed {
    logic [LEN_W-1:0] count;
    logic             flush;
  } job_ctl_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] lo,
                                                 input logic [LEN_W-1:0] hi);
    logic [LEN_W-1:0] r;
    r = len;
    if (len < lo) r = lo;
    if (len > hi) r = hi;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/swr_front.sv @@
`default_nettype none

module swr_front #(
  parameter int N = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire swr_pkg::cfg_t     cfg,
  input  wire logic              push,
  input  wire logic              action,
  input  wire logic [7:0]        text_byte,
  input  wire logic              jq_full,
  output logic                   full,
  output logic                   job_push,
  output logic [8*N-1:0]         job_bytes,
  output swr_pkg::job_ctl_t      job_ctl
);
  import swr_pkg::*;

  localparam logic [LEN_W-1:0] NMAX = LEN_W'(N);

  logic [7:0]       held [N];
  logic [7:0]       held_next [N];
  logic [LEN_W-1:0] hcnt;

  logic [7:0]       cand [N];
  logic [7:0]       sw [N];
  logic [N-1:0]     ok;
  logic [LEN_W-1:0] slen, rlen, n, st, keep;
  logic             stale, match, accept, reset_hold;

  assign slen   = clamp_len(cfg.search_len, LEN_W'(1), NMAX);
  assign rlen   = clamp_len(cfg.replace_len, LEN_W'(0), NMAX);
  assign n      = hcnt + LEN_W'(1);
  assign accept = push && !jq_full;
  assign full   = jq_full;

  // candidate run: held bytes with the new byte appended
  always_comb begin
    for (int i = 0; i < N; i++) begin
      sw[i] = cfg.search_word[8*i +: 8];
      if (LEN_W'(i) < hcnt) cand[i] = held[i];
      else cand[i] = text_byte;
    end
  end

  // ok[s]: the tail of the candidate from s on is a prefix of the search word
  always_comb begin
    for (int s = 0; s < N; s++) begin
      ok[s] = 1'b1;
      for (int j = 0; j < N; j++) begin
        if ((s + j < N) && (LEN_W'(s + j) < n) && (cand[(s+j)%N] != sw[j])) ok[s] = 1'b0;
      end
    end
  end

  // leftmost start that still matches; n if none does
  always_comb begin
    st = n;
    for (int s = N - 1; s >= 0; s--) begin
      if ((LEN_W'(s) < n) && ok[s]) st = LEN_W'(s);
    end
  end

  assign keep  = n - st;
  assign stale = hcnt >= slen;
  assign match = (n == slen) && ok[0];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      held_next[i] = 8'h00;
      for (int s = 0; s < N; s++) begin
        if ((LEN_W'(s) == st) && (s + i < N)) held_next[i] = cand[(s+i)%N];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) job_bytes[8*i +: 8] = cand[i];
    job_ctl.flush = 1'b0;
    priority if (action) begin
      job_ctl.count = hcnt;
      job_ctl.flush = 1'b1;
    end else if (stale) begin
      job_ctl.count = n;
    end else if (match) begin
      job_ctl.count = rlen;
      job_bytes     = cfg.replace_word[8*N-1:0];
    end else begin
      job_ctl.count = st;
    end
  end

  assign reset_hold = action || stale || match;
  assign job_push   = accept && (action || (job_ctl.count != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      hcnt <= '0;
    end else if (accept) begin
      hcnt <= reset_hold ? '0 : keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !reset_hold) begin
      for (int i = 0; i < N; i++) held[i] <= held_next[i];
    end
  end

endmodule

`default_nettype wire

@@ design/swr_jobq.sv @@
`default_nettype none

module swr_jobq #(
  parameter int W = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [W-1:0]       push_bytes,
  input  wire swr_pkg::job_ctl_t  push_ctl,
  output logic                    full,
  input  wire logic               pop,
  output logic [W-1:0]            head_bytes,
  output swr_pkg::job_ctl_t       head_ctl,
  output logic                    empty
);
  import swr_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  logic [W-1:0] mem_bytes [2];
  job_ctl_t     mem_ctl [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   cnt;
  logic         do_push, do_pop;

  assign full    = cnt == DEPTH;
  assign empty   = cnt == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign head_bytes = mem_bytes[rd_ptr];
  assign head_ctl   = mem_ctl[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_bytes[wr_ptr] <= push_bytes;
      mem_ctl[wr_ptr]   <= push_ctl;
    end
  end

endmodule

`default_nettype wire

@@ design/swr_back.sv @@
`default_nettype none

module swr_back #(
  parameter int N = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               jq_empty,
  input  wire logic [8*N-1:0]     job_bytes,
  input  wire swr_pkg::job_ctl_t  job_ctl,
  output logic                    jq_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [7:0]              out_byte,
  output logic                    has_byte,
  output logic                    last_of_run,
  output logic                    text_end
);
  import swr_pkg::*;

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic [7:0]       b [N];
  logic [LEN_W-1:0] idx;
  logic             out_valid, go, marker, is_last;

  always_comb begin
    for (int i = 0; i < N; i++) b[i] = job_bytes[8*i +: 8];
  end

  assign marker  = job_ctl.count == '0;
  assign is_last = marker || (idx == job_ctl.count - LEN_W'(1));
  assign go      = !jq_empty && (!out_valid || pop);
  assign jq_pop  = go && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (go) begin
      out_valid <= 1'b1;
      idx       <= is_last ? '0 : idx + LEN_W'(1);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte    <= marker ? 8'h00 : b[idx[IW-1:0]];
      has_byte    <= !marker;
      last_of_run <= is_last;
      text_end    <= is_last && job_ctl.flush;
    end
  end

endmodule

`default_nettype wire

@@ design/stream_word_replace.sv @@
`default_nettype none
// Channel   Handshake           Payload
// input     push / full         action, text_byte
// result    empty / pop         out_byte, has_byte, last_of_run, text_end
// config    cfg_write           cfg_index, cfg_data
//
// The front takes one item a cycle while the job queue has room; its match
// check over all start positions settles in that same cycle.
// The back emits one result a cycle while pop does not stall it, so an item's
// results leave in a row (a held byte adds none); the job queue decouples the two.
// Reset is synchronous; no clearing pass is needed after it.
// A stall on pop holds the output register, then fills the queue, then raises full.

module stream_word_replace #(
  parameter int MAX_WORD_BYTES = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [swr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [swr_pkg::WORD_W-1:0]       cfg_data,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             action,
  input  wire logic [7:0]                       text_byte,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic [7:0]                            out_byte,
  output logic                                  has_byte,
  output logic                                  last_of_run,
  output logic                                  text_end
);
  import swr_pkg::*;

  localparam int JW = 8 * MAX_WORD_BYTES;

  cfg_t          cfg;
  logic          job_push, jq_full, jq_empty, jq_pop;
  logic [JW-1:0] job_bytes, head_bytes;
  job_ctl_t      job_ctl, head_ctl;

  // configuration registers; user writes only while the block is idle (unchecked)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_word  <= '0;
      cfg.search_len   <= LEN_W'(1);
      cfg.replace_word <= '0;
      cfg.replace_len  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEARCH_WORD:    cfg.search_word  <= cfg_data;
        REG_SEARCH_LENGTH:  cfg.search_len   <= cfg_data[LEN_W-1:0];
        REG_REPLACE_WORD:   cfg.replace_word <= cfg_data;
        REG_REPLACE_LENGTH: cfg.replace_len  <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  // front: holds the partial match, decides what each item releases
  swr_front #(.N(MAX_WORD_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .action    (action),
    .text_byte (text_byte),
    .jq_full   (jq_full),
    .full      (full),
    .job_push  (job_push),
    .job_bytes (job_bytes),
    .job_ctl   (job_ctl)
  );

  // two-deep job queue between the halves
  swr_jobq #(.W(JW)) u_jobq (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_bytes (job_bytes),
    .push_ctl   (job_ctl),
    .full       (jq_full),
    .pop        (jq_pop),
    .head_bytes (head_bytes),
    .head_ctl   (head_ctl),
    .empty      (jq_empty)
  );

  // back: serialises each job into result items
  swr_back #(.N(MAX_WORD_BYTES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .jq_empty    (jq_empty),
    .job_bytes   (head_bytes),
    .job_ctl     (head_ctl),
    .jq_pop      (jq_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .last_of_run (last_of_run),
    .text_end    (text_end)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
  import swr_pkg::*;

  // item kinds on the action port
  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam int MAX_BYTES     = 8;
  localparam int SETTLE_CYCLES = 8;    // margin for held-only items
  localparam int TAIL_CYCLES   = 30;   // quiet time at the end to catch stray results
  localparam int HOLD_CYCLES   = 300;  // long pop hold-off for the back-pressure test
  localparam int STALL_LIMIT   = 4000; // cycles with no handshake before giving up
  localparam int MAX_REPORTS   = 100;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       text_end;
  } byte_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data  = '0;
  logic                 push      = 1'b0;
  logic                 action    = ACT_TEXT;
  logic [7:0]           text_byte = 8'h00;
  logic                 pop       = 1'b0;
  logic                 full;
  logic                 empty;
  logic [7:0]           out_byte;
  logic                 has_byte;
  logic                 last_of_run;
  logic                 text_end;

  stream_word_replace dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .action      (action),
    .text_byte   (text_byte),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .last_of_run (last_of_run),
    .text_end    (text_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers and of the held-back text.
  // held_text keeps held byte i in bits 8i+7..8i, same layout as the words.
  // ---------------------------------------------------------------------------
  logic [63:0] srch_word = '0;
  logic [3:0]  srch_len  = 4'd1;
  logic [63:0] repl_word = '0;
  logic [3:0]  repl_len  = 4'd0;
  logic [63:0] held_text = '0;
  int          held_n    = 0;

  byte_result_t rewritten_q [$];   // results owed by the block, oldest first
  int           err_count   = 0;

  // idling knobs, percent per cycle; set by the test tasks
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // pop hold-off request: bump the ticket, the receiver does the counting
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  task automatic flag_mismatch(input string what);
    if (err_count < MAX_REPORTS) $display("mismatch @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic byte_result_t make_result(input logic [7:0] b, input logic has);
    byte_result_t r;
    r.out_byte    = b;
    r.has_byte    = has;
    r.last_of_run = 1'b0;
    r.text_end    = 1'b0;
    return r;
  endfunction

  // zero means one, anything past eight saturates
  function automatic int search_span();
    if (srch_len == 4'd0) return 1;
    if (srch_len > 4'(MAX_BYTES)) return MAX_BYTES;
    return int'(srch_len);
  endfunction

  // does cand[from .. from+n-1] equal the first n bytes of the search word?
  function automatic bit is_word_prefix(input logic [63:0] cand, input int from, input int n);
    int i;
    for (i = 0; i < n; i++)
      if (cand[8*(from+i) +: 8] != srch_word[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Work out what one accepted item makes the block emit, and queue it.
  task automatic rewrite_item(input logic act, input logic [7:0] b);
    byte_result_t run [$];
    logic [63:0]  cand;
    int           span, rspan, n, start, i;
    span  = search_span();
    rspan = (repl_len > 4'(MAX_BYTES)) ? MAX_BYTES : int'(repl_len);
    if (act == ACT_END) begin
      // flush: every held byte, or a bare end marker if none
      for (i = 0; i < held_n; i++) run.push_back(make_result(held_text[8*i +: 8], 1'b1));
      held_n = 0;
      if (run.size() == 0) run.push_back(make_result(8'h00, 1'b0));
      run[run.size()-1].text_end = 1'b1;
    end else if (held_n >= span) begin
      // search length dropped under the hold: dump it all plus the new byte
      for (i = 0; i < held_n; i++) run.push_back(make_result(held_text[8*i +: 8], 1'b1));
      run.push_back(make_result(b, 1'b1));
      held_n = 0;
    end else begin
      cand = held_text;
      cand[8*held_n +: 8] = b;
      n = held_n + 1;
      if (n == span && is_word_prefix(cand, 0, n)) begin
        for (i = 0; i < rspan; i++) run.push_back(make_result(repl_word[8*i +: 8], 1'b1));
        held_n = 0;
      end else begin
        // release oldest bytes until the rest is a prefix again
        start = 0;
        while (start < n && !is_word_prefix(cand, start, n - start)) begin
          run.push_back(make_result(cand[8*start +: 8], 1'b1));
          start++;
        end
        held_n = n - start;
        held_text = cand >> (8 * start);
      end
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) rewritten_q.push_back(run[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Driving. push is left high after an accepted item so that back-to-back
  // items never lower and raise it in one step; settle() drops it.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    action    <= act;
    text_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    rewrite_item(act, b);
  endtask

  // wait until every owed result is out and the front has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_write high; caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SEARCH_WORD:    srch_word = data;
      REG_SEARCH_LENGTH:  srch_len  = data[3:0];
      REG_REPLACE_WORD:   repl_word = data;
      REG_REPLACE_LENGTH: repl_len  = data[3:0];
      default: ;
    endcase
  endtask

  // length in the low nibble, junk above it (ignored by the block)
  function automatic logic [63:0] len_word(input logic [3:0] len);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[3:0] = len;
    return d;
  endfunction

  task automatic set_config(input logic [63:0] sw, input logic [3:0] sl,
                            input logic [63:0] rw, input logic [3:0] rl);
    write_reg(REG_SEARCH_WORD, sw);
    write_reg(REG_SEARCH_LENGTH, len_word(sl));
    write_reg(REG_REPLACE_WORD, rw);
    write_reg(REG_REPLACE_LENGTH, len_word(rl));
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random pop, or a counted hold-off when one is requested.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Checker: each popped result against the oldest owed one.
  always @(posedge clk) begin : check_results
    byte_result_t want;
    if (!rst && pop && !empty) begin
      if (rewritten_q.size() == 0) begin
        flag_mismatch($sformatf("result %02h/%0b with none owed", out_byte, has_byte));
      end else begin
        want = rewritten_q.pop_front();
        if (out_byte !== want.out_byte)
          flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
        if (has_byte !== want.has_byte)
          flag_mismatch($sformatf("has_byte %0b, want %0b", has_byte, want.has_byte));
        if (last_of_run !== want.last_of_run)
          flag_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run, want.last_of_run));
        if (text_end !== want.text_end)
          flag_mismatch($sformatf("text_end %0b, want %0b", text_end, want.text_end));
      end
    end
  end

  // Watchdog: too long without any handshake on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: search word is a single 00 byte, replacement empty
  task automatic test_reset_values();
    send_item(ACT_TEXT, 8'h00);   // matches, deleted, no result
    send_item(ACT_TEXT, 8'hFF);
    send_item(ACT_END, 8'hA5);    // nothing held: bare end marker
    send_item(ACT_END, 8'h5A);
  endtask

  // "abc" -> "XY" over "ababcd": partial run released byte by byte
  task automatic test_partial_release();
    settle();
    set_config(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
    send_item(ACT_TEXT, 8'h61);
    send_item(ACT_TEXT, 8'h62);
    send_item(ACT_TEXT, 8'h61);   // "aba" fails, a and b go out, a stays
    send_item(ACT_TEXT, 8'h62);
    send_item(ACT_TEXT, 8'h63);   // match
    send_item(ACT_TEXT, 8'h64);
  endtask

  // over-range lengths saturate: 8-byte word replaced by 8 bytes
  task automatic test_full_width_words();
    int i;
    settle();
    set_config(64'hFF00_7F80_0102_FE01, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd12);
    for (i = 0; i < MAX_BYTES; i++) send_item(ACT_TEXT, srch_word[8*i +: 8]);
  endtask

  // search length zero acts as one; replacement length zero deletes
  task automatic test_delete_and_zero_length();
    settle();
    set_config(64'h0000_0000_0000_0041, 4'd0, {$urandom, $urandom}, 4'd0);
    send_item(ACT_TEXT, 8'h41);
    send_item(ACT_TEXT, 8'h42);
    send_item(ACT_END, 8'h00);
  endtask

  // hold "abc", then shrink the word under it: next byte dumps all
  task automatic test_stale_hold();
    settle();
    set_config(64'h0000_0000_6463_6261, 4'd4, 64'h0000_0000_0000_002A, 4'd1);
    send_item(ACT_TEXT, 8'h61);
    send_item(ACT_TEXT, 8'h62);
    send_item(ACT_TEXT, 8'h63);
    settle();
    write_reg(REG_SEARCH_LENGTH, len_word(4'd2));
    cfg_write <= 1'b0;
    send_item(ACT_TEXT, 8'h7A);
  endtask

  // hold "ab", swap the word to "abxy": held bytes judged against the new word
  task automatic test_word_swap_while_holding();
    settle();
    set_config(64'h0000_0000_6463_6261, 4'd4, 64'h0000_0000_0000_002A, 4'd1);
    send_item(ACT_TEXT, 8'h61);
    send_item(ACT_TEXT, 8'h62);
    settle();
    write_reg(REG_SEARCH_WORD, 64'h0000_0000_7978_6261);
    cfg_write <= 1'b0;
    send_item(ACT_TEXT, 8'h78);
    send_item(ACT_END, 8'hFF);    // flush with three bytes held
  endtask

  // random word setup; half the words use two symbols so they overlap themselves
  task automatic pick_random_config();
    logic [63:0] w;
    logic [7:0]  sym_a, sym_b;
    logic [3:0]  sl, rl;
    int          i, pick;
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    w = {$urandom, $urandom};
    if ($urandom_range(1) == 1)
      for (i = 0; i < MAX_BYTES; i++) w[8*i +: 8] = ($urandom_range(1) == 1) ? sym_a : sym_b;
    pick = $urandom_range(5);
    case (pick)
      0:       sl = 4'd1;
      1:       sl = 4'd8;
      2:       sl = ($urandom_range(1) == 1) ? 4'd0 : 4'($urandom_range(15, 9));
      default: sl = 4'($urandom_range(8, 1));
    endcase
    pick = $urandom_range(5);
    case (pick)
      0:       rl = 4'd0;
      1:       rl = 4'd8;
      2:       rl = 4'($urandom_range(15, 9));
      default: rl = 4'($urandom_range(8, 0));
    endcase
    set_config(w, sl, {$urandom, $urandom}, rl);
  endtask

  // Mostly whole words and word fragments with random content, some noise.
  task automatic test_random_text(input int n_items, input int tx_pct, input int rx_pct);
    int sent, seg, r, cut, span, i, idx;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      settle();
      pick_random_config();
      span = search_span();
      for (seg = 0; seg < 25 && sent < n_items; seg++) begin
        r = $urandom_range(99);
        if (r < 40) begin
          for (i = 0; i < span; i++) send_item(ACT_TEXT, srch_word[8*i +: 8]);
          sent += span;
        end else if (r < 60) begin
          // fragment, then whatever byte
          cut = $urandom_range(span, 1);
          for (i = 0; i < cut; i++) send_item(ACT_TEXT, srch_word[8*i +: 8]);
          send_item(ACT_TEXT, 8'($urandom));
          sent += cut + 1;
        end else if (r < 92) begin
          if ($urandom_range(1) == 1) begin
            idx = $urandom_range(span - 1);
            send_item(ACT_TEXT, srch_word[8*idx +: 8]);
          end else begin
            send_item(ACT_TEXT, 8'($urandom));
          end
          sent++;
        end else begin
          send_item(ACT_END, 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  // pop held off for a long stretch while items keep coming: queue fills, full rises
  task automatic test_backpressure();
    int i;
    settle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_config(64'h0000_0000_0000_0061, 4'd1, {$urandom, $urandom}, 4'd8);
    hold_ticket++;
    for (i = 0; i < 40; i++)
      send_item(ACT_TEXT, ($urandom_range(3) == 0) ? 8'($urandom) : 8'h61);
    send_item(ACT_END, 8'h00);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_partial_release();
    test_full_width_words();
    test_delete_and_zero_length();
    test_stale_hold();
    test_word_swap_while_holding();

    test_random_text(100, 0, 0);
    test_random_text(100, 71, 0);
    test_random_text(100, 0, 71);
    test_random_text(100, 37, 37);

    test_backpressure();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rewritten_q.size() != 0)
      flag_mismatch($sformatf("%0d results never came out", rewritten_q.size()));

    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
